// ===== design/sensor_table_interpolator_top_macros.svh =====
// assertion macros for the sensor table interpolator
// used by sensor_table_interpolator_top; expects clk and rst in scope
`ifndef SENSOR_TABLE_INTERPOLATOR_TOP_MACROS_SVH
`define SENSOR_TABLE_INTERPOLATOR_TOP_MACROS_SVH

// condition implies consequence in the same cycle
`define STI_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// condition implies consequence in the next cycle
`define STI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/sti_pkg.sv =====
// shared types and constants for the sensor table interpolator
// no dependencies
`timescale 1ns / 1ps

package sti_pkg;

  localparam int CH_W      = 3;
  localparam int IDX_W     = 6;
  localparam int KEY_W     = 16;
  localparam int VAL_W     = 16;
  localparam int CFG_W     = 7;
  localparam int NUM_REGS  = 8;
  localparam int CFG_IDX_W = 3;
  localparam int S_DATA_W  = 48;
  localparam int M_DATA_W  = 16;
  localparam int DIV_W     = 32;

  typedef enum logic {
    REQ_LOAD    = 1'b0,
    REQ_CONVERT = 1'b1
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_MUL,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== design/sensor_table_interpolator_top.sv =====
// A load word goes from acceptance straight to its result, as does a convert on an empty
// table or an out-of-range channel. Any other convert word reads the breakpoints it needs
// (up to the match or bracket, or all in use on a miss), one memory read per breakpoint,
// and when it interpolates adds a multiply, then the 32-step bit-serial divider.
// One word at a time; the next word is accepted the cycle after the result is registered,
// and a stalled output holds the result back until the output register is free.
// Reset clears the count registers and held results; the breakpoint memory is not cleared.
// top level: sequencer, count and held registers, output register
// depends on sti_pkg, sti_table, sti_div, sensor_table_interpolator_top_macros.svh
`timescale 1ns / 1ps

module sensor_table_interpolator_top import sti_pkg::*; #(
  parameter int CHANNELS = 8,
  parameter int ENTRIES  = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  // channel, entry_index, raw_key, entry_value (lowest bits first), zero padded
  input  logic [S_DATA_W-1:0]  s_tdata,
  // req_type
  input  logic                 s_tuser,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // calibrated
  output logic [M_DATA_W-1:0]  m_tdata,
  // in_range
  output logic                 m_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

`include "sensor_table_interpolator_top_macros.svh"

  localparam int DEPTH = CHANNELS * ENTRIES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int HW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // input fields
  logic [CH_W-1:0]         in_channel;
  logic [IDX_W-1:0]        in_index;
  logic [KEY_W-1:0]        in_key;
  logic signed [VAL_W-1:0] in_value;

  assign in_channel = s_tdata[2:0];
  assign in_index   = s_tdata[8:3];
  assign in_key     = s_tdata[24:9];
  assign in_value   = $signed(s_tdata[40:25]);

  state_t state, state_next;

  logic [CFG_W-1:0]        entries_reg [NUM_REGS];
  logic signed [VAL_W-1:0] held [CHANNELS];

  logic [KEY_W-1:0]        key_reg;
  logic [CH_W-1:0]         ch_reg;
  logic [AW-1:0]           base_reg;
  logic [CNT_W-1:0]        n_reg;
  logic [CNT_W-1:0]        rd_ptr;
  logic [CNT_W-1:0]        chk_ptr;
  logic                    rvalid;
  logic [KEY_W-1:0]        prev_key;
  logic signed [VAL_W-1:0] prev_val;
  logic [KEY_W-1:0]        mul_a;
  logic signed [VAL_W:0]   mul_b;
  logic [KEY_W-1:0]        den_reg;
  logic signed [33:0]      prod;
  logic                    neg_reg;
  logic signed [VAL_W-1:0] res_val;
  logic                    res_flag;

  logic                    accept;
  logic                    is_load;
  logic                    ch_ok;
  logic [CFG_W-1:0]        in_count;
  logic [CNT_W-1:0]        in_n;
  logic                    tbl_we;
  logic [AW-1:0]           tbl_waddr;
  logic                    tbl_re;
  logic [AW-1:0]           tbl_raddr;
  logic [KEY_W-1:0]        rd_key;
  logic signed [VAL_W-1:0] rd_val;
  logic                    bracket;
  logic                    match;
  logic                    last;
  logic                    out_free;
  logic                    div_start;
  logic [33:0]             prod_mag;
  logic [DIV_W-1:0]        div_quo;
  div_stat_t               div_stat;
  logic [VAL_W+1:0]        q_signed;
  logic [VAL_W+1:0]        interp_sum;

  // accept and request decode
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign is_load  = (req_t'(s_tuser) == REQ_LOAD);
  assign ch_ok    = 32'(in_channel) < CHANNELS;
  assign in_count = entries_reg[in_channel];
  assign in_n     = (32'(in_count) > ENTRIES) ? CNT_W'(ENTRIES) : CNT_W'(in_count);

  // breakpoint write on load
  assign tbl_we    = accept && is_load && ch_ok && (32'(in_index) < ENTRIES);
  assign tbl_waddr = AW'(32'(in_channel) * ENTRIES + 32'(in_index));

  // sequential read of the channel's breakpoints
  assign tbl_re    = (state == ST_SEARCH) && (rd_ptr < n_reg);
  assign tbl_raddr = base_reg + AW'(rd_ptr);

  sti_table #(.DEPTH(DEPTH), .AW(AW)) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wkey  (in_key),
    .wval  (in_value),
    .re    (tbl_re),
    .raddr (tbl_raddr),
    .rkey  (rd_key),
    .rval  (rd_val)
  );

  // compare the entry just read against the key
  assign bracket = (chk_ptr != '0) && (key_reg > prev_key) && (key_reg < rd_key);
  assign match   = (key_reg == rd_key);
  assign last    = (chk_ptr == CNT_W'(n_reg - 1'b1));

  // divider takes the magnitude of the product
  assign prod_mag  = prod[33] ? 34'(-prod) : 34'(prod);
  assign div_start = (state == ST_DIV_GO);

  sti_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod_mag[DIV_W-1:0]),
    .divisor  (den_reg),
    .quotient (div_quo),
    .stat     (div_stat)
  );

  // quotient truncated toward zero, added to the lower breakpoint value
  assign q_signed   = neg_reg ? (VAL_W+2)'(-{1'b0, div_quo[VAL_W:0]})
                              : {1'b0, div_quo[VAL_W:0]};
  assign interp_sum = {{2{prev_val[VAL_W-1]}}, prev_val} + q_signed;

  assign out_free = !m_tvalid || m_tready;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (is_load || !ch_ok || (in_n == '0)) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        if (rvalid) begin
          priority if (bracket) begin
            state_next = ST_MUL;
          end else if (match || last) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_SEARCH;
          end
        end
      end
      ST_MUL:      state_next = ST_DIV_GO;
      ST_DIV_GO:   state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_stat.done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // count registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        entries_reg[i] <= '0;
      end
    end else if (cfg_we) begin
      entries_reg[cfg_index] <= cfg_data;
    end
  end

  // held results, updated whenever a convert lands in range
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        held[i] <= '0;
      end
    end else if (state == ST_SEARCH && rvalid && !bracket && match) begin
      held[HW'(ch_reg)] <= rd_val;
    end else if (state == ST_DIV_WAIT && div_stat.done) begin
      held[HW'(ch_reg)] <= $signed(interp_sum[VAL_W-1:0]);
    end
  end

  // search control
  always_ff @(posedge clk) begin
    if (rst) begin
      rvalid <= 1'b0;
    end else if (state == ST_SEARCH) begin
      rvalid <= tbl_re && !(rvalid && (bracket || match || last));
    end else begin
      rvalid <= 1'b0;
    end
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        key_reg  <= in_key;
        ch_reg   <= in_channel;
        base_reg <= AW'(32'(in_channel) * ENTRIES);
        n_reg    <= in_n;
        rd_ptr   <= '0;
        chk_ptr  <= '0;
        res_flag <= 1'b0;
        if (is_load || !ch_ok) begin
          res_val <= '0;
        end else begin
          res_val <= held[HW'(in_channel)];
        end
      end
      ST_SEARCH: begin
        if (tbl_re) begin
          rd_ptr <= rd_ptr + 1'b1;
        end
        if (rvalid) begin
          priority if (bracket) begin
            mul_a   <= key_reg - prev_key;
            mul_b   <= {rd_val[VAL_W-1], rd_val} - {prev_val[VAL_W-1], prev_val};
            den_reg <= rd_key - prev_key;
          end else if (match) begin
            res_val  <= rd_val;
            res_flag <= 1'b1;
          end else begin
            prev_key <= rd_key;
            prev_val <= rd_val;
            chk_ptr  <= chk_ptr + 1'b1;
          end
        end
      end
      ST_MUL: begin
        prod <= mul_b * $signed({1'b0, mul_a});
      end
      ST_DIV_GO: begin
        neg_reg <= prod[33];
      end
      ST_DIV_WAIT: begin
        if (div_stat.done) begin
          res_val  <= $signed(interp_sum[VAL_W-1:0]);
          res_flag <= 1'b1;
        end
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      m_tdata <= res_val;
      m_tuser <= res_flag;
    end
  end

  // checks
  `STI_ASSERT_SAME(a_div_free, div_start, !div_stat.busy, "divider started while busy")
  `STI_ASSERT_SAME(a_ptr_bound, state == ST_SEARCH, rd_ptr <= n_reg && chk_ptr < n_reg, "search pointer past breakpoint count")
  `STI_ASSERT_NEXT(a_out_load, state == ST_DONE && out_free, m_tvalid && state == ST_IDLE, "result not presented after completion")
  `STI_ASSERT_SAME(a_done_wait, div_stat.done, state == ST_DIV_WAIT, "divider finished outside wait state")

endmodule

// ===== design/sti_table.sv =====
// breakpoint memory: key and value per entry, one write and one registered read port
// depends on sti_pkg
`timescale 1ns / 1ps

module sti_table import sti_pkg::*; #(
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [AW-1:0]           waddr,
  input  logic [KEY_W-1:0]        wkey,
  input  logic signed [VAL_W-1:0] wval,
  input  logic                    re,
  input  logic [AW-1:0]           raddr,
  output logic [KEY_W-1:0]        rkey,
  output logic signed [VAL_W-1:0] rval
);

  logic [KEY_W+VAL_W-1:0] mem [DEPTH];
  logic [KEY_W+VAL_W-1:0] rdata;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wval, wkey};
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  assign rkey = rdata[KEY_W-1:0];
  assign rval = $signed(rdata[KEY_W+VAL_W-1:KEY_W]);

endmodule

// ===== design/sti_div.sv =====
// bit-serial restoring divider, unsigned, one quotient bit per cycle
// depends on sti_pkg
`timescale 1ns / 1ps

module sti_div import sti_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [KEY_W-1:0] divisor,
  output logic [DIV_W-1:0] quotient,
  output div_stat_t        stat
);

  localparam int CNT_W = $clog2(DIV_W);

  logic [KEY_W-1:0] rem;
  logic [KEY_W-1:0] den;
  logic [DIV_W-1:0] quo;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [KEY_W:0]   trial;
  logic             fits;

  // one shift-subtract step
  assign trial = {rem, quo[DIV_W-1]};
  assign fits  = trial >= {1'b0, den};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      rem <= '0;
      quo <= dividend;
      den <= divisor;
    end else if (busy) begin
      rem <= fits ? KEY_W'(trial - {1'b0, den}) : trial[KEY_W-1:0];
      quo <= {quo[DIV_W-2:0], fits};
    end
  end

  assign quotient  = quo;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule
